### rtl/core/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, frame layout constants and the crc-16 byte update
// ----------------------------------------------------------------------------
package pfc_pkg;

  // frame layout
  localparam logic [8:0] HDR_LEN      = 9'd34;
  localparam logic [8:0] PAYLEN_POS   = 9'd29;
  localparam logic [8:0] PAYCRC_POS   = 9'd30;
  localparam logic [8:0] HDRCRC_POS   = 9'd32;
  localparam logic [8:0] HDR_CRC_END  = HDR_LEN - 9'd2;
  localparam logic [8:0] COUNT_MAX    = 9'd511;

  // crc-16/ccitt
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
  localparam logic [7:0]  VERSION_RESET  = 8'd1;

  // configuration register indexes
  localparam logic CFG_CRC_SEED    = 1'b0;
  localparam logic CFG_EXP_VERSION = 1'b1;

  typedef enum logic [3:0] {
    TAG_VERSION = 4'd0,
    TAG_TYPE    = 4'd1,
    TAG_MSGID   = 4'd2,
    TAG_SRC     = 4'd3,
    TAG_DST     = 4'd4,
    TAG_FRAGIDX = 4'd5,
    TAG_FRAGTOT = 4'd6,
    TAG_TTL     = 4'd7,
    TAG_HOPS    = 4'd8,
    TAG_FLAGS   = 4'd9,
    TAG_PAYLEN  = 4'd10,
    TAG_PAYCRC  = 4'd11,
    TAG_HDRCRC  = 4'd12,
    TAG_PAYLOAD = 4'd13,
    TAG_EXCESS  = 4'd14
  } field_tag_t;

  typedef enum logic [2:0] {
    VERDICT_OK      = 3'd0,
    VERDICT_SHORT   = 3'd1,
    VERDICT_LEN     = 3'd2,
    VERDICT_HDR_CRC = 3'd3,
    VERDICT_PAY_CRC = 3'd4,
    VERDICT_VERSION = 3'd5
  } verdict_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // header field of a byte offset; payload vs excess from the declared length
  function automatic field_tag_t field_tag_of(input logic [8:0] off, input logic [7:0] paylen);
    field_tag_t tag;
    if (off <= 9'd1) begin
      tag = (off[0]) ? TAG_TYPE : TAG_VERSION;
    end else if (off <= 9'd3) begin
      tag = TAG_MSGID;
    end else if (off <= 9'd13) begin
      tag = TAG_SRC;
    end else if (off <= 9'd23) begin
      tag = TAG_DST;
    end else if (off <= PAYLEN_POS) begin
      case (off[2:0])
        3'd0:    tag = TAG_FRAGIDX;  // offset 24
        3'd1:    tag = TAG_FRAGTOT;
        3'd2:    tag = TAG_TTL;
        3'd3:    tag = TAG_HOPS;
        3'd4:    tag = TAG_FLAGS;
        default: tag = TAG_PAYLEN;
      endcase
    end else if (off <= 9'd31) begin
      tag = TAG_PAYCRC;
    end else if (off <= 9'd33) begin
      tag = TAG_HDRCRC;
    end else if ({1'b0, off} < ({1'b0, HDR_LEN} + {2'b00, paylen})) begin
      tag = TAG_PAYLOAD;
    end else begin
      tag = TAG_EXCESS;
    end
    return tag;
  endfunction

endpackage

### rtl/core/pfc_in_if.sv
// ----------------------------------------------------------------------------
// pfc_in_if
// received byte channel: valid/ready with one frame byte and its last flag
// ----------------------------------------------------------------------------
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source (output valid, output rx_byte, output frame_last, input ready);
  modport sink   (input valid, input rx_byte, input frame_last, output ready);
endinterface

### rtl/core/pfc_out_if.sv
// ----------------------------------------------------------------------------
// pfc_out_if
// result channel: echoed byte with field tag, offset and frame verdict
// ----------------------------------------------------------------------------
interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_echo;
  logic [3:0] field_tag;
  logic [8:0] byte_offset;
  logic       frame_done;
  logic [2:0] verdict;

  modport source (output valid, output byte_echo, output field_tag, output byte_offset,
                  output frame_done, output verdict, input ready);
  modport sink   (input valid, input byte_echo, input field_tag, input byte_offset,
                  input frame_done, input verdict, output ready);
endinterface

### rtl/core/packet_frame_checker.sv
// ----------------------------------------------------------------------------
// packet_frame_checker
// byte-serial radio frame checker with header and payload crc-16 and verdict
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | contents
//  ---------+-----+---------------+----------------------------------------------
//  in_ch    | in  | valid / ready | rx_byte, frame_last
//  out_ch   | out | valid / ready | byte_echo, field_tag, byte_offset, frame_done,
//           |     |               | verdict
//  cfg_*    | in  | cfg_we only   | cfg_index, cfg_wdata (crc seed, version)
//
//  one byte per cycle sustained while out_ch takes results; an accepted byte
//  goes into the input register, and its result on to the result register
//  the per-cycle work is a byte-wide crc update plus two 16-bit crc compares
//  sync active-low reset clears control and frame state, config regs take reset
//  values; no clearing pass is needed
//  a stall on out_ch holds the result register, then the input register, then
//  drops in_ch.ready; both stages keep moving while the result is taken
//
module packet_frame_checker
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pfc_in_if.sink      in_ch,
  pfc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration
  logic [15:0] crc_seed_r;
  logic [7:0]  exp_version_r;

  // input register stage
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_adv;
  logic        s1_fire;

  // frame state
  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [15:0] hdr_crc_r, hdr_crc_nxt;
  logic [15:0] pay_crc_r, pay_crc_nxt;
  logic [7:0]  paylen_r, paylen_nxt;
  logic [15:0] rx_pay_crc_r, rx_pay_crc_nxt;
  logic [15:0] rx_hdr_crc_r, rx_hdr_crc_nxt;
  logic [7:0]  version_r, version_nxt;

  // result register
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  field_tag_t  out_tag_r, tag_nxt;
  logic [8:0]  out_offset_r;
  logic        out_done_r;
  verdict_t    out_verdict_r, verdict_nxt;

  logic [8:0]  off;
  logic [15:0] pay_crc_final;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_seed_r    <= CRC_SEED_RESET;
      exp_version_r <= VERSION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_SEED:    crc_seed_r    <= cfg_wdata;
        default:         exp_version_r <= cfg_wdata[7:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: result register frees first, input register follows
  // ---------------------------------------------------------------------------
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_last_r <= in_ch.frame_last;
    end
  end

  // ---------------------------------------------------------------------------
  // per-byte frame logic
  // ---------------------------------------------------------------------------
  assign off = byte_count_r;

  always_comb begin
    version_nxt    = version_r;
    paylen_nxt     = paylen_r;
    rx_pay_crc_nxt = rx_pay_crc_r;
    rx_hdr_crc_nxt = rx_hdr_crc_r;
    hdr_crc_nxt    = hdr_crc_r;
    pay_crc_nxt    = pay_crc_r;

    // capture header fields
    if (off == 9'd0) begin
      version_nxt = s1_byte_r;
    end
    if (off == PAYLEN_POS) begin
      paylen_nxt = s1_byte_r;
    end
    // received crcs arrive big endian
    if (off == PAYCRC_POS) begin
      rx_pay_crc_nxt[15:8] = s1_byte_r;
    end else if (off == PAYCRC_POS + 9'd1) begin
      rx_pay_crc_nxt[7:0] = s1_byte_r;
    end else if (off == HDRCRC_POS) begin
      rx_hdr_crc_nxt[15:8] = s1_byte_r;
    end else if (off == HDRCRC_POS + 9'd1) begin
      rx_hdr_crc_nxt[7:0] = s1_byte_r;
    end

    // header crc over bytes 0..31, seeded at byte 0
    if (off < HDR_CRC_END) begin
      hdr_crc_nxt = crc16_byte((off == 9'd0) ? crc_seed_r : hdr_crc_r, s1_byte_r);
    end
    // payload crc from byte 34 on, seeded there; excess bytes are included
    if (off >= HDR_LEN) begin
      pay_crc_nxt = crc16_byte((off == HDR_LEN) ? crc_seed_r : pay_crc_r, s1_byte_r);
    end
  end

  // empty payload means the crc never left the seed
  assign pay_crc_final = (paylen_nxt == 8'd0) ? crc_seed_r : pay_crc_nxt;

  always_comb begin
    tag_nxt     = field_tag_of(off, paylen_r);
    verdict_nxt = VERDICT_OK;
    if (s1_last_r) begin
      // frame length is off + 1; compare against 34 + declared payload
      if (off < HDR_LEN - 9'd1) begin
        verdict_nxt = VERDICT_SHORT;
      end else if ({1'b0, off} != ({1'b0, HDR_LEN - 9'd1} + {2'b00, paylen_nxt})) begin
        verdict_nxt = VERDICT_LEN;
      end else if (hdr_crc_nxt != rx_hdr_crc_nxt) begin
        verdict_nxt = VERDICT_HDR_CRC;
      end else if (pay_crc_final != rx_pay_crc_nxt) begin
        verdict_nxt = VERDICT_PAY_CRC;
      end else if (version_nxt != exp_version_r) begin
        verdict_nxt = VERDICT_VERSION;
      end
    end
  end

  // offset counter: restarts after the last byte, saturates on long frames
  always_comb begin
    if (s1_last_r) begin
      byte_count_nxt = 9'd0;
    end else if (byte_count_r < COUNT_MAX) begin
      byte_count_nxt = byte_count_r + 9'd1;
    end else begin
      byte_count_nxt = byte_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 9'd0;
      hdr_crc_r    <= CRC_SEED_RESET;
      pay_crc_r    <= CRC_SEED_RESET;
      paylen_r     <= 8'd0;
      rx_pay_crc_r <= 16'd0;
      rx_hdr_crc_r <= 16'd0;
      version_r    <= 8'd0;
    end else if (s1_fire) begin
      byte_count_r <= byte_count_nxt;
      hdr_crc_r    <= hdr_crc_nxt;
      pay_crc_r    <= pay_crc_nxt;
      paylen_r     <= paylen_nxt;
      rx_pay_crc_r <= rx_pay_crc_nxt;
      rx_hdr_crc_r <= rx_hdr_crc_nxt;
      version_r    <= version_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_byte_r    <= s1_byte_r;
      out_tag_r     <= tag_nxt;
      out_offset_r  <= off;
      out_done_r    <= s1_last_r;
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_echo   = out_byte_r;
  assign out_ch.field_tag   = out_tag_r;
  assign out_ch.byte_offset = out_offset_r;
  assign out_ch.frame_done  = out_done_r;
  assign out_ch.verdict     = out_verdict_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_verdict_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> out_verdict_r == VERDICT_OK)
    else $error("verdict set on a byte that is not the last of its frame");

  a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> byte_count_r == 9'd0)
    else $error("offset counter did not restart after the last byte");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !s1_last_r && byte_count_r != COUNT_MAX
      |=> byte_count_r == $past(byte_count_r) + 9'd1)
    else $error("offset counter did not advance by one");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a byte under stall");

  a_offset_matches: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_offset_r == $past(byte_count_r))
    else $error("result offset differs from the counter");

endmodule

### tb/pfc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_tb_pkg
// crc-16/ccitt byte step shared by frame generation and result prediction
// ----------------------------------------------------------------------------
package pfc_tb_pkg;

  import pfc_pkg::*;

  // feeds the data byte in bit by bit, msb first
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    int k;
    r = acc;
    for (k = 7; k >= 0; k--) begin
      if (r[15] ^ d[k]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### tb/pfc_frame_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_frame_monitor
// watches the byte, result and register ports, predicts every result
// transaction and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module pfc_frame_monitor
  import pfc_pkg::*;
  import pfc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_echo,
  input  logic [3:0]  out_tag,
  input  logic [8:0]  out_offset,
  input  logic        out_done,
  input  logic [2:0]  out_verdict,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          err_count,
  output int          pend_count,
  output int          bytes_checked,
  output int          frames_checked,
  output logic [5:0]  verdicts_seen
);

  typedef struct packed {
    logic [7:0] echo;
    field_tag_t tag;
    logic [8:0] offset;
    logic       done;
    verdict_t   verdict;
  } byte_result_t;

  byte_result_t pending_results[$];

  // register copies
  logic [15:0] seed_reg;
  logic [7:0]  exp_version;

  // frame state
  logic [8:0]  byte_pos;
  logic [15:0] hdr_acc;
  logic [15:0] pay_acc;
  logic [7:0]  decl_len;
  logic [15:0] rx_pay_crc;
  logic [15:0] rx_hdr_crc;
  logic [7:0]  fr_version;

  function automatic field_tag_t tag_for(input logic [8:0] pos);
    field_tag_t t;
    if (pos >= HDR_LEN) begin
      t = ({1'b0, pos} < {1'b0, HDR_LEN} + {2'b00, decl_len}) ? TAG_PAYLOAD : TAG_EXCESS;
    end else if (pos >= HDRCRC_POS) begin
      t = TAG_HDRCRC;
    end else if (pos >= PAYCRC_POS) begin
      t = TAG_PAYCRC;
    end else begin
      case (pos)
        9'd0:    t = TAG_VERSION;
        9'd1:    t = TAG_TYPE;
        9'd2,
        9'd3:    t = TAG_MSGID;
        9'd24:   t = TAG_FRAGIDX;
        9'd25:   t = TAG_FRAGTOT;
        9'd26:   t = TAG_TTL;
        9'd27:   t = TAG_HOPS;
        9'd28:   t = TAG_FLAGS;
        9'd29:   t = TAG_PAYLEN;
        default: t = (pos <= 9'd13) ? TAG_SRC : TAG_DST;
      endcase
    end
    return t;
  endfunction

  task automatic predict_byte_result(input logic [7:0] b, input logic last,
                                     output byte_result_t r);
    logic [8:0] pos;
    logic [9:0] flen;
    verdict_t   v;
    pos = byte_pos;
    if (pos == 9'd0) fr_version = b;
    if (pos == PAYLEN_POS) decl_len = b;
    r.tag = tag_for(pos);
    if (pos == PAYCRC_POS) begin
      rx_pay_crc[15:8] = b;
    end else if (pos == PAYCRC_POS + 9'd1) begin
      rx_pay_crc[7:0] = b;
    end else if (pos == HDRCRC_POS) begin
      rx_hdr_crc[15:8] = b;
    end else if (pos == HDRCRC_POS + 9'd1) begin
      rx_hdr_crc[7:0] = b;
    end
    if (pos < HDR_CRC_END) hdr_acc = crc16_step((pos == 9'd0) ? seed_reg : hdr_acc, b);
    if (pos >= HDR_LEN) pay_acc = crc16_step((pos == HDR_LEN) ? seed_reg : pay_acc, b);
    v = VERDICT_OK;
    if (last) begin
      flen = {1'b0, pos} + 10'd1;
      if (flen < {1'b0, HDR_LEN}) begin
        v = VERDICT_SHORT;
      end else if (flen != {1'b0, HDR_LEN} + {2'b00, decl_len}) begin
        v = VERDICT_LEN;
      end else if (hdr_acc != rx_hdr_crc) begin
        v = VERDICT_HDR_CRC;
      end else if (((decl_len == 8'd0) ? seed_reg : pay_acc) != rx_pay_crc) begin
        v = VERDICT_PAY_CRC;
      end else if (fr_version != exp_version) begin
        v = VERDICT_VERSION;
      end
      byte_pos = 9'd0;
    end else if (byte_pos != COUNT_MAX) begin
      byte_pos = byte_pos + 9'd1;
    end
    r.echo    = b;
    r.offset  = pos;
    r.done    = last;
    r.verdict = v;
  endtask

  // one line per mismatch, then count it
  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("pfc monitor: result %0d %s got %0d want %0d", bytes_checked, what, got_v,
             want_v);
    err_count++;
  endtask

  always @(posedge clk) begin : watch
    byte_result_t want;
    if (!rst_n) begin
      seed_reg       = CRC_SEED_RESET;
      exp_version    = VERSION_RESET;
      byte_pos       = 9'd0;
      hdr_acc        = CRC_SEED_RESET;
      pay_acc        = CRC_SEED_RESET;
      decl_len       = 8'd0;
      rx_pay_crc     = 16'd0;
      rx_hdr_crc     = 16'd0;
      fr_version     = 8'd0;
      err_count      = 0;
      bytes_checked  = 0;
      frames_checked = 0;
      verdicts_seen  = '0;
      pending_results.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        if (cfg_index == CFG_CRC_SEED) begin
          seed_reg = cfg_wdata;
        end else begin
          exp_version = cfg_wdata[7:0];
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        predict_byte_result(in_byte, in_last, want);
        pending_results.push_back(want);
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        bytes_checked++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected, byte_echo", out_echo, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_echo !== want.echo) report_mismatch("byte_echo", out_echo, want.echo);
          if (out_tag !== want.tag) report_mismatch("field_tag", out_tag, want.tag);
          if (out_offset !== want.offset) report_mismatch("byte_offset", out_offset, want.offset);
          if (out_done !== want.done) report_mismatch("frame_done", out_done, want.done);
          if (out_verdict !== want.verdict) report_mismatch("verdict", out_verdict, want.verdict);
          if (want.done) begin
            frames_checked++;
            verdicts_seen[want.verdict] = 1'b1;
          end
        end
      end
    end
    pend_count <= pending_results.size();
  end

endmodule

### tb/packet_frame_checker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_frame_checker_test
// drives framed bytes into the frame checker: good frames, header and payload
// crc errors, wrong versions, short, mis-sized and overlong frames, across
// several crc seed and version settings with random idling on both channels;
// the monitor beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module packet_frame_checker_test;

  import pfc_pkg::*;
  import pfc_tb_pkg::*;

  localparam int BYTE_BUDGET   = 1650;
  localparam int PHASES        = 6;
  localparam int HOLD_CYCLES   = 120;        // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;          // two-stage pipe plus margin
  localparam int TIMEOUT_NS    = 40_000_000; // far beyond the slowest legal run

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  int         err_count;
  int         pend_count;
  int         bytes_checked;
  int         frames_checked;
  logic [5:0] verdicts_seen;

  // frame under construction, one byte per entry
  logic [7:0] frame_q[$];

  // what the block's registers hold right now
  logic [15:0] cur_seed;
  logic [7:0]  cur_ver;

  int bytes_sent  = 0;
  int reg_writes  = 0;
  int hold_ticket = 0;  // bumped to ask the receiver for one long hold-off
  bit tx_gaps;          // sender idles between transactions
  bit rx_stalls;        // receiver drops ready at random

  packet_frame_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pfc_frame_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_byte        (in_ch.rx_byte),
    .in_last        (in_ch.frame_last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_echo       (out_ch.byte_echo),
    .out_tag        (out_ch.field_tag),
    .out_offset     (out_ch.byte_offset),
    .out_done       (out_ch.frame_done),
    .out_verdict    (out_ch.verdict),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .err_count      (err_count),
    .pend_count     (pend_count),
    .bytes_checked  (bytes_checked),
    .frames_checked (frames_checked),
    .verdicts_seen  (verdicts_seen)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("packet_frame_checker_test: done, errors");
    $finish;
  end

  // idle length: mostly none, often short, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // payload length: mostly tiny, some medium, a few near the maximum
  function automatic int pick_plen();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 8);
    if (roll < 95) return $urandom_range(9, 40);
    return $urandom_range(200, 255);
  endfunction

  // result side: random ready, plus one long hold-off per ticket
  initial begin : result_sink
    int served;
    int n;
    served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        // block fills up behind this while the sender keeps offering
        served = hold_ticket;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = rx_stalls ? gap_len() : 0;
        if (n == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (n - 1) @(posedge clk);
        end
      end
    end
  end

  // one byte transaction, then maybe an idle stretch
  task automatic send_byte(input logic [7:0] b, input logic last);
    int n;
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= b;
    in_ch.frame_last <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    n = tx_gaps ? gap_len() : 0;
    if (n > 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom_range(0, 255));  // junk while idle
      repeat (n) @(posedge clk);
    end
  endtask

  // bytes lo..hi-1 of the frame; the last flag rides on its final byte
  task automatic send_part(input int lo, input int hi);
    int i;
    for (i = lo; i < hi; i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // sender pauses until every result is back and the pipe is empty
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pend_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // well-formed frame; header and payload crcs may start from different seeds
  task automatic build_good(input logic [7:0] ver, input logic [7:0] plen,
                            input logic [15:0] hseed, input logic [15:0] pseed);
    logic [7:0]  pay[$];
    logic [15:0] pc;
    logic [15:0] hc;
    int          i;
    pc = pseed;
    for (i = 0; i < plen; i++) begin
      pay.push_back(8'($urandom_range(0, 255)));
      pc = crc16_step(pc, pay[i]);
    end
    frame_q.delete();
    frame_q.push_back(ver);
    for (i = 1; i < PAYLEN_POS; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(plen);
    frame_q.push_back(pc[15:8]);
    frame_q.push_back(pc[7:0]);
    // header crc covers everything up to the payload crc inclusive
    hc = hseed;
    for (i = 0; i < HDR_CRC_END; i++) hc = crc16_step(hc, frame_q[i]);
    frame_q.push_back(hc[15:8]);
    frame_q.push_back(hc[7:0]);
    for (i = 0; i < plen; i++) frame_q.push_back(pay[i]);
  endtask

  // runs past the offset counter limit so it saturates
  task automatic build_long();
    int n;
    build_good(cur_ver, 8'($urandom_range(0, 255)), cur_seed, cur_seed);
    n = $urandom_range(512, 530);
    while (frame_q.size() < n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_random_frame();
    int         roll;
    int         plen;
    int         pos;
    int         n;
    logic [7:0] m;
    roll = $urandom_range(0, 99);
    plen = pick_plen();
    m    = 8'($urandom_range(1, 255));
    if (roll < 45) begin
      build_good(cur_ver, 8'(plen), cur_seed, cur_seed);
    end else if (roll < 53) begin
      // damage one header byte, never the length field
      build_good(cur_ver, 8'(plen), cur_seed, cur_seed);
      pos = $urandom_range(0, HDR_LEN - 1);
      if (pos == PAYLEN_POS) pos = PAYLEN_POS - 1;
      frame_q[pos] = frame_q[pos] ^ m;
    end else if (roll < 61) begin
      // damage one payload byte, header stays consistent
      if (plen == 0) plen = 1;
      build_good(cur_ver, 8'(plen), cur_seed, cur_seed);
      pos = $urandom_range(HDR_LEN, HDR_LEN - 1 + plen);
      frame_q[pos] = frame_q[pos] ^ m;
    end else if (roll < 68) begin
      build_good(cur_ver ^ m, 8'(plen), cur_seed, cur_seed);
    end else if (roll < 76) begin
      // length disagrees with the declared payload: cut short or excess bytes
      build_good(cur_ver, 8'(plen), cur_seed, cur_seed);
      if (plen > 0 && $urandom_range(0, 1) == 1) begin
        n = $urandom_range(1, plen);
        repeat (n) frame_q.pop_back();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      end
    end else if (roll < 86) begin
      // ends inside the header
      build_good(cur_ver, 8'(plen), cur_seed, cur_seed);
      n = $urandom_range(1, HDR_LEN - 1);
      while (frame_q.size() > n) frame_q.pop_back();
    end else if (roll < 98) begin
      frame_q.delete();
      n = $urandom_range(1, 70);
      repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      build_long();
    end
  endtask

  initial begin : stimulus
    int          ph;
    int          split;
    int          phase_end;
    logic [15:0] nseed;
    logic [7:0]  nver;
    logic [7:0]  hi;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_CRC_SEED;
    cfg_wdata        <= 16'd0;
    in_ch.valid      <= 1'b0;
    in_ch.rx_byte    <= 8'd0;
    in_ch.frame_last <= 1'b0;
    rx_stalls        <= 1'b1;
    tx_gaps   = 1'b1;
    cur_seed  = CRC_SEED_RESET;
    cur_ver   = VERSION_RESET;
    split     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-byte frames at both byte extremes, then the smallest
    // valid frame under reset settings
    frame_q = '{8'h00};
    send_part(0, 1);
    frame_q = '{8'hFF};
    send_part(0, 1);
    build_good(cur_ver, 8'd0, cur_seed, cur_seed);
    send_part(0, frame_q.size());

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          nseed = CRC_SEED_RESET;
          nver  = VERSION_RESET;
        end
        1: begin
          nseed = 16'h0000;
          nver  = 8'h00;
        end
        3: begin
          nseed = 16'h1D0F;
          nver  = 8'hFF;
        end
        5: begin
          nseed = 16'hFFFF;
          nver  = 8'h80;
        end
        default: begin
          nseed = 16'($urandom_range(0, 65535));
          nver  = 8'($urandom_range(0, 255));
        end
      endcase

      // seed change in the middle of a frame: header crc keeps the old seed,
      // payload crc picks up the new one at its load point
      if (ph == 4) begin
        build_good(nver, 8'($urandom_range(0, 6)), cur_seed, nseed);
        split = $urandom_range(1, HDR_LEN);
        send_part(0, split);
      end

      drain_results();
      hi = 8'($urandom_range(0, 255));
      write_reg(CFG_CRC_SEED, nseed);
      write_reg(CFG_EXP_VERSION, {hi, nver});
      cur_seed = nseed;
      cur_ver  = nver;

      // phase 2 runs flat out on both sides
      tx_gaps = (ph != 2);
      rx_stalls <= (ph != 2);

      if (ph == 4) send_part(split, frame_q.size());

      if (ph == 3) begin
        // long receiver hold-off against a back-to-back sender
        hold_ticket <= hold_ticket + 1;
        tx_gaps = 1'b0;
        build_good(cur_ver, 8'd24, cur_seed, cur_seed);
        send_part(0, frame_q.size());
        tx_gaps = 1'b1;
        drain_results();
        build_long();
        send_part(0, frame_q.size());
      end

      phase_end = BYTE_BUDGET * (ph + 1) / PHASES;
      while (bytes_sent < phase_end) begin
        build_random_frame();
        send_part(0, frame_q.size());
      end
    end

    drain_results();
    $display("packet_frame_checker_test: %0d results over %0d frames, %0d register writes",
             bytes_checked, frames_checked, reg_writes);
    $display("packet_frame_checker_test: verdict codes seen %b, with hold-off and seed change",
             verdicts_seen);
    if (err_count == 0 && pend_count == 0) begin
      $display("packet_frame_checker_test: done, clean");
    end else begin
      $display("packet_frame_checker_test: done, errors");
    end
    $finish;
  end

endmodule
